@@ rtl/mck_pkg.sv @@
`timescale 1ns / 1ps
package mck_pkg;

  localparam logic [2:0] KIND_DOT  = 3'd0;
  localparam logic [2:0] KIND_DASH = 3'd1;
  localparam logic [2:0] KIND_EGAP = 3'd2;
  localparam logic [2:0] KIND_LGAP = 3'd3;
  localparam logic [2:0] KIND_WGAP = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;

  localparam logic [15:0] UNIT_TICKS_RESET     = 16'd20;
  localparam logic [19:0] WORD_GAP_TICKS_RESET = 20'd200;

  localparam logic [7:0] CHAR_A = 8'h61;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // element count per letter
  localparam logic [2:0] PAT_LEN [0:25] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // element bits, msb first from bit len-1, 1 = dash
  localparam logic [3:0] PAT_BITS [0:25] = '{
    4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
    4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_word;
  } char_t;

  typedef struct packed {
    logic        pin_level;
    logic [19:0] duration;
    logic [2:0]  segment_kind;
    logic        last;
  } seg_t;

  // classified character: pattern left-aligned so bit 3 is the next element
  typedef struct packed {
    logic       err;
    logic [2:0] cnt;
    logic [3:0] pat;
    logic       eow;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } q_stat_t;

  function automatic logic [3:0] align_pat(input logic [3:0] bits, input logic [2:0] len);
    logic [3:0] res;
    case (len)
      3'd1:    res = {bits[0], 3'b000};
      3'd2:    res = {bits[1:0], 2'b00};
      3'd3:    res = {bits[2:0], 1'b0};
      default: res = bits;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/morse_code_keyer_core.sv @@
`timescale 1ns / 1ps
// Morse keyer: each accepted character becomes a run of LED segments, one
// segment per clock on the output channel when the sink keeps ready high. A
// letter produces 2*n+1 segments for an n-element pattern (plus one word gap
// segment when end_of_word is set); any byte outside a..z produces one error
// segment. The segment sequencer emits one segment per cycle while the sink
// is ready; a two-entry command queue in front of it lets characters be
// accepted while the current one is still being sent. Registers: unit_ticks at
// 0x0, word_gap_ticks at 0x4; write them only while no segments are pending.
module morse_code_keyer_core import mck_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  char_t       in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output seg_t        out_seg,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] unit_ticks;
  logic [19:0] word_gap_ticks;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head;
  q_stat_t     q_stat;
  logic [19:0] dash_ticks;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {12'd0, word_gap_ticks} : {16'd0, unit_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks     <= UNIT_TICKS_RESET;
      word_gap_ticks <= WORD_GAP_TICKS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        word_gap_ticks <= pwdata[19:0];
      end else begin
        unit_ticks <= pwdata[15:0];
      end
    end
  end

  mck_front u_front (
    .in_item  (in_item),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  mck_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mck_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .unit_ticks     (unit_ticks),
    .word_gap_ticks (word_gap_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_seg        (out_seg)
  );

  assign dash_ticks = {3'b000, unit_ticks, 1'b0} + {4'b0000, unit_ticks};

  a_err_seg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_seg.segment_kind == KIND_ERR |->
      out_seg.last && out_seg.pin_level && out_seg.duration == 20'd0)
    else $error("error segment malformed");

  a_mark_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_seg.segment_kind == KIND_DOT || out_seg.segment_kind == KIND_DASH) |->
      !out_seg.pin_level && !out_seg.last)
    else $error("mark segment must light the led and never end a character");

  a_dash_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_seg.segment_kind == KIND_DASH |-> out_seg.duration == dash_ticks)
    else $error("dash duration is not three units");

  a_egap_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready &&
    (out_seg.segment_kind == KIND_DOT || out_seg.segment_kind == KIND_DASH) |=>
      out_valid && out_seg.segment_kind == KIND_EGAP)
    else $error("mark not followed by element gap");

endmodule

@@ rtl/mck_front.sv @@
`timescale 1ns / 1ps
module mck_front import mck_pkg::*; (
  input  char_t   in_item,
  input  logic    in_valid,
  output logic    in_ready,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    cmd
);

  logic [7:0] off;
  logic [4:0] idx;
  logic       is_letter;

  always_comb begin
    off       = in_item.char_code - CHAR_A;
    idx       = off[4:0];
    is_letter = in_item.char_code inside {[8'h61:8'h7A]};
    cmd.err   = !is_letter;
    cmd.eow   = in_item.end_of_word;
    if (is_letter) begin
      cmd.cnt = PAT_LEN[idx];
      cmd.pat = align_pat(PAT_BITS[idx], PAT_LEN[idx]);
    end else begin
      cmd.cnt = 3'd0;
      cmd.pat = 4'd0;
    end
  end

  assign in_ready = q_stat.ready;
  assign push     = in_valid && q_stat.ready;

endmodule

@@ rtl/mck_queue.sv @@
`timescale 1ns / 1ps
module mck_queue import mck_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;

  assign head         = entry[rptr];
  assign q_stat.valid = count != '0;
  assign q_stat.ready = count != Q_CNT_W'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/mck_back.sv @@
`timescale 1ns / 1ps
module mck_back import mck_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  q_stat_t     q_stat,
  output logic        pop,
  input  logic [15:0] unit_ticks,
  input  logic [19:0] word_gap_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output seg_t        out_seg
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MARK = 3'd1;
  localparam logic [2:0] ST_EGAP = 3'd2;
  localparam logic [2:0] ST_LGAP = 3'd3;
  localparam logic [2:0] ST_WGAP = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [2:0]  cnt;
  logic [2:0]  cnt_next;
  logic [3:0]  pat;
  logic [3:0]  pat_next;
  logic        eow;
  logic        eow_next;
  logic        load;
  logic        emit;
  seg_t        seg_next;
  logic [19:0] d_one;
  logic [19:0] d_two;
  logic [19:0] d_three;

  assign d_one   = {4'b0000, unit_ticks};
  assign d_two   = {3'b000, unit_ticks, 1'b0};
  assign d_three = d_two + d_one;

  // output register is free when empty or being taken this cycle
  assign load = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pat_next   = pat;
    eow_next   = eow;
    seg_next   = out_seg;
    emit       = 1'b0;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_stat.valid && load) begin
          pop  = 1'b1;
          emit = 1'b1;
          if (head.err) begin
            seg_next = '{pin_level: 1'b1, duration: 20'd0, segment_kind: KIND_ERR,
                         last: 1'b1};
          end else begin
            seg_next = '{pin_level: 1'b0, duration: head.pat[3] ? d_three : d_one,
                         segment_kind: head.pat[3] ? KIND_DASH : KIND_DOT, last: 1'b0};
            pat_next   = {head.pat[2:0], 1'b0};
            cnt_next   = head.cnt - 3'd1;
            eow_next   = head.eow;
            state_next = ST_EGAP;
          end
        end
      end
      ST_MARK: begin
        if (load) begin
          emit       = 1'b1;
          seg_next   = '{pin_level: 1'b0, duration: pat[3] ? d_three : d_one,
                         segment_kind: pat[3] ? KIND_DASH : KIND_DOT, last: 1'b0};
          pat_next   = {pat[2:0], 1'b0};
          cnt_next   = cnt - 3'd1;
          state_next = ST_EGAP;
        end
      end
      ST_EGAP: begin
        if (load) begin
          emit       = 1'b1;
          seg_next   = '{pin_level: 1'b1, duration: d_one, segment_kind: KIND_EGAP,
                         last: 1'b0};
          state_next = (cnt == 3'd0) ? ST_LGAP : ST_MARK;
        end
      end
      ST_LGAP: begin
        if (load) begin
          emit       = 1'b1;
          seg_next   = '{pin_level: 1'b1, duration: d_two, segment_kind: KIND_LGAP,
                         last: !eow};
          state_next = eow ? ST_WGAP : ST_IDLE;
        end
      end
      ST_WGAP: begin
        if (load) begin
          emit       = 1'b1;
          seg_next   = '{pin_level: 1'b1, duration: word_gap_ticks, segment_kind: KIND_WGAP,
                         last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    pat     <= pat_next;
    eow     <= eow_next;
    out_seg <= seg_next;
  end

endmodule

@@ bench/morse_code_keyer_core_tb.sv @@
`timescale 1ns / 1ps
module morse_code_keyer_core_tb;
  import mck_pkg::*;

  localparam logic [2:0] ADDR_UNIT_TICKS     = 3'h0;
  localparam logic [2:0] ADDR_WORD_GAP_TICKS = 3'h4;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int CHARS_PER_PHASE = 30;
  localparam int NUM_PHASES      = 7;

  // any byte outside a..z gives this one dark segment
  localparam seg_t BAD_CHAR_SEG = {1'b1, 20'd0, KIND_ERR, 1'b1};

  typedef struct packed {
    char_t item;
    logic  typed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  char_t       in_item;
  logic        out_valid;
  logic        out_ready;
  seg_t        out_seg;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  seg_t        expected_segs [$];
  stim_row_t   directed_rows [$];
  seg_t        seg_want;
  logic [15:0] unit_cfg;
  logic [19:0] word_gap_cfg;
  logic        typed_now;
  bit          src_idle;
  bit          sink_stalls;
  int          errors;
  int          cycle_count;

  morse_code_keyer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_seg   (out_seg),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic string morse_of(input logic [7:0] ch);
    case (ch)
      "a": return ".-";
      "b": return "-...";
      "c": return "-.-.";
      "d": return "-..";
      "e": return ".";
      "f": return "..-.";
      "g": return "--.";
      "h": return "....";
      "i": return "..";
      "j": return ".---";
      "k": return "-.-";
      "l": return ".-..";
      "m": return "--";
      "n": return "-.";
      "o": return "---";
      "p": return ".--.";
      "q": return "--.-";
      "r": return ".-.";
      "s": return "...";
      "t": return "-";
      "u": return "..-";
      "v": return "...-";
      "w": return ".--";
      "x": return "-..-";
      "y": return "-.--";
      "z": return "--..";
      default: return "";
    endcase
  endfunction

  function automatic seg_t mk_seg(input logic level, input logic [19:0] dur,
                                  input logic [2:0] kind, input logic fin);
    seg_t s;
    s.pin_level    = level;
    s.duration     = dur;
    s.segment_kind = kind;
    s.last         = fin;
    return s;
  endfunction

  // queue up the segments one character should produce
  function automatic void predict_segments(input char_t c);
    string       code;
    logic [19:0] unit20;
    unit20 = {4'd0, unit_cfg};
    if (c.char_code < "a" || c.char_code > "z") begin
      expected_segs.push_back(BAD_CHAR_SEG);
      return;
    end
    code = morse_of(c.char_code);
    for (int i = 0; i < code.len(); i++) begin
      if (code[i] == "-")
        expected_segs.push_back(mk_seg(1'b0, unit20 * 20'd3, KIND_DASH, 1'b0));
      else
        expected_segs.push_back(mk_seg(1'b0, unit20, KIND_DOT, 1'b0));
      expected_segs.push_back(mk_seg(1'b1, unit20, KIND_EGAP, 1'b0));
    end
    expected_segs.push_back(mk_seg(1'b1, unit20 << 1, KIND_LGAP, !c.end_of_word));
    if (c.end_of_word)
      expected_segs.push_back(mk_seg(1'b1, word_gap_cfg, KIND_WGAP, 1'b1));
  endfunction

  function automatic void check_field(input string name, input logic [19:0] want,
                                      input logic [19:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic char_t random_char();
    char_t c;
    if ($urandom_range(0, 9) < 8)
      c.char_code = CHAR_A + 8'($urandom_range(0, 25));
    else
      c.char_code = 8'($urandom_range(0, 255));
    c.end_of_word = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  task automatic add_row(input logic [7:0] ch, input logic eow, input logic typed);
    stim_row_t r;
    r.item.char_code   = ch;
    r.item.end_of_word = eow;
    r.typed            = typed;
    directed_rows.push_back(r);
  endtask

  task automatic send_char(input char_t c, input logic typed);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= c;
    typed_now <= typed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_UNIT_TICKS)
      unit_cfg = data[15:0];
    else if (addr == ADDR_WORD_GAP_TICKS)
      word_gap_cfg = data[19:0];
    @(posedge clk);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // predict on every accepted character, check every accepted segment
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (typed_now)
          expected_segs.push_back(BAD_CHAR_SEG);
        else
          predict_segments(in_item);
      end
      if (out_valid && out_ready) begin
        if (expected_segs.size() == 0) begin
          $display("%0t: unexpected transaction, expected none got %h", $time, out_seg);
          errors++;
        end else begin
          seg_want = expected_segs.pop_front();
          check_field("pin_level", 20'(seg_want.pin_level), 20'(out_seg.pin_level));
          check_field("duration", seg_want.duration, out_seg.duration);
          check_field("segment_kind", 20'(seg_want.segment_kind),
                      20'(out_seg.segment_kind));
          check_field("last", 20'(seg_want.last), 20'(out_seg.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d segments outstanding", $time, expected_segs.size());
      $display("status: fail");
      $finish;
    end
  end

  // sink side: random stall bursts while enabled
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_stalls && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] unit_val;
    logic [31:0] gap_val;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_item      <= '0;
    typed_now    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    unit_cfg     = UNIT_TICKS_RESET;
    word_gap_cfg = WORD_GAP_TICKS_RESET;
    errors       = 0;
    cycle_count  = 0;
    src_idle     = 1'b1;
    sink_stalls  = 1'b1;

    // bad bytes: both ends of the byte, either side of a..z, uppercase, space
    add_row(8'h00, 1'b0, 1'b1);
    add_row(8'hFF, 1'b1, 1'b1);
    add_row(8'h60, 1'b0, 1'b1);
    add_row(8'h7B, 1'b1, 1'b1);
    add_row(8'h41, 1'b0, 1'b1);
    add_row(8'h20, 1'b1, 1'b1);
    add_row("a", 1'b0, 1'b0);
    add_row("z", 1'b1, 1'b0);
    add_row("e", 1'b0, 1'b0);
    add_row("t", 1'b1, 1'b0);
    add_row("h", 1'b0, 1'b0);
    add_row("o", 1'b1, 1'b0);
    add_row("q", 1'b0, 1'b0);
    add_row("b", 1'b1, 1'b0);
    add_row("j", 1'b1, 1'b0);
    add_row("y", 1'b0, 1'b0);
    add_row("s", 1'b1, 1'b0);
    add_row("m", 1'b0, 1'b0);
    add_row("c", 1'b1, 1'b0);
    add_row("x", 1'b0, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset register values first
    foreach (directed_rows[i])
      send_char(directed_rows[i].item, directed_rows[i].typed);
    finish_phase();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          unit_val = 32'd1;
          gap_val  = 32'd0;
        end
        1: begin
          unit_val = 32'd65535;
          gap_val  = 32'h000F_FFFF;
        end
        2: begin
          // zero unit, all element durations collapse to zero
          unit_val = 32'd0;
          gap_val  = 32'd5;
        end
        3: begin
          // upper bits must be dropped by the register widths
          unit_val = 32'hFFFF_FFFF;
          gap_val  = 32'hFFFF_FFFF;
        end
        default: begin
          unit_val = $urandom_range(1, 65535);
          gap_val  = $urandom_range(0, 32'h000F_FFFF);
        end
      endcase
      write_reg(ADDR_UNIT_TICKS, unit_val);
      write_reg(ADDR_WORD_GAP_TICKS, gap_val);
      src_idle    = (p != 2) && (p != NUM_PHASES - 1);
      sink_stalls = src_idle;
      repeat (CHARS_PER_PHASE) send_char(random_char(), 1'b0);
      finish_phase();
    end

    repeat (16) @(posedge clk);
    if (errors == 0 && expected_segs.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/mck_pkg.sv
rtl/mck_front.sv
rtl/mck_queue.sv
rtl/mck_back.sv
rtl/morse_code_keyer_core.sv
bench/morse_code_keyer_core_tb.sv
